/* rtl/idrt_pkg.sv */
// Shared widths, constants and register indexes of the interval debt rate throttle.
`default_nettype none

package idrt_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int TIME_W        = 64;
    localparam int CREDIT_W      = 48;
    localparam int RATE_W        = 32;
    localparam int IVAL_W        = 32;
    localparam int DELAY_W       = 32;
    localparam int CFG_W         = 48;
    localparam int CFG_IDX_W     = 2;

    // Divider width covers both the time span and the scaled credit debt.
    localparam int DIV_W = (TIME_W > CREDIT_W + FRACTION_BITS) ?
                           TIME_W : CREDIT_W + FRACTION_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int S_TDATA_W = ((TIME_W + CREDIT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DELAY_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CREDIT   = 2'd2;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_CHARGE  = 1'b1;

endpackage

`default_nettype wire

/* rtl/idrt_div.sv */
// Shared iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module idrt_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [idrt_pkg::DIV_W-1:0] dividend,
    input  wire logic [idrt_pkg::DIV_W-1:0] divisor,
    output logic                            done,
    output logic [idrt_pkg::DIV_W-1:0]      quot,
    output logic [idrt_pkg::DIV_W-1:0]      rem
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [idrt_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [idrt_pkg::DIV_W-1:0]      quot_reg;
    logic [idrt_pkg::DIV_W-1:0]      rem_reg;
    logic [idrt_pkg::DIV_W-1:0]      dvsr_reg;
    logic [idrt_pkg::DIV_W:0]        shifted;
    logic [idrt_pkg::DIV_W:0]        trial;

    assign shifted = {rem_reg, quot_reg[idrt_pkg::DIV_W-1]};
    assign trial   = shifted - {1'b0, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // pulse on the cycle after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= idrt_pkg::DIV_CNT_W'(idrt_pkg::DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // keep the difference when it does not go negative
            if (!trial[idrt_pkg::DIV_W])
            begin
                rem_reg  <= trial[idrt_pkg::DIV_W-1:0];
                quot_reg <= {quot_reg[idrt_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[idrt_pkg::DIV_W-1:0];
                quot_reg <= {quot_reg[idrt_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* rtl/interval_debt_rate_throttle_top.sv */
// Top level of the interval debt rate throttle: registers, sequencer and shared divider.
// A restart or a charge with rate 0 goes straight to the finish state; a charge runs
// up to three divisions, a multiply-subtract loop and the control states.
// Throughput: one item at a time; s_tready is high only while the sequencer is idle.
// The shared 64-bit divider (one quotient bit per cycle) sets the charge time.
// Reset: rst_n asynchronous active low; rate 0, interval 1, allowance 0,
// window deadline 0, used credit 0, no result pending.
`default_nettype none

module interval_debt_rate_throttle_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [idrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [idrt_pkg::CFG_W-1:0]          cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [63:0] now_ticks, [111:64] amount
    input  wire logic [idrt_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] opcode
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] delay_ms
    output logic [idrt_pkg::M_TDATA_W-1:0]           m_tdata
);

    localparam int TW = idrt_pkg::TIME_W;
    localparam int CW = idrt_pkg::CREDIT_W;
    localparam int DW = idrt_pkg::DIV_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CU_DIV,
        ST_CU_EVAL,
        ST_S_DIV,
        ST_S_EVAL,
        ST_MUL,
        ST_W_CHECK,
        ST_W_DIV,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t                         state_reg;
    logic [idrt_pkg::RATE_W-1:0]    rate_reg;
    logic [idrt_pkg::IVAL_W-1:0]    ival_cfg_reg;
    logic [CW-1:0]                  allow_reg;
    logic [TW-1:0]                  dl_reg;
    logic [CW-1:0]                  used_reg;
    logic [TW-1:0]                  now_reg;
    logic [CW-1:0]                  amt_reg;
    logic [TW-1:0]                  q_reg;
    logic [TW-1:0]                  base_reg;
    logic [CW-1:0]                  s_reg;
    logic [CW-1:0]                  m_reg;
    logic [CW-1:0]                  ashift_reg;
    logic [idrt_pkg::DELAY_W-1:0]   delay_reg;
    logic                           m_tvalid_reg;
    logic [idrt_pkg::DELAY_W-1:0]   m_data_reg;
    logic                           div_start_reg;
    logic [DW-1:0]                  div_dividend_reg;
    logic [DW-1:0]                  div_divisor_reg;

    logic                           div_done;
    logic [DW-1:0]                  div_quot;
    logic [DW-1:0]                  div_rem;

    logic [TW-1:0]                  ival;
    logic [TW-1:0]                  in_now;
    logic [CW-1:0]                  in_amt;
    logic                           accept;
    logic [CW:0]                    used_sum;

    assign in_now   = s_tdata[TW-1:0];
    assign in_amt   = s_tdata[TW+CW-1:TW];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign ival     = (ival_cfg_reg == '0) ? TW'(1) : TW'(ival_cfg_reg);
    assign used_sum = {1'b0, used_reg} + {1'b0, amt_reg};

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] x, input logic [TW-1:0] y);
        logic [TW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[TW] ? '1 : s[TW-1:0];
    endfunction

    idrt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  (div_divisor_reg),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= '0;
            ival_cfg_reg <= idrt_pkg::IVAL_W'(1);
            allow_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                idrt_pkg::CFG_RATE:     rate_reg     <= cfg_data[idrt_pkg::RATE_W-1:0];
                idrt_pkg::CFG_INTERVAL: ival_cfg_reg <= cfg_data[idrt_pkg::IVAL_W-1:0];
                idrt_pkg::CFG_CREDIT:   allow_reg    <= cfg_data[CW-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dl_reg        <= '0;
            used_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
        end
        else
        begin
            // drop the result after its transfer unless a new one is loaded
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        now_reg   <= in_now;
                        amt_reg   <= in_amt;
                        delay_reg <= '0;
                        if (s_tuser == idrt_pkg::OP_RESTART)
                        begin
                            dl_reg    <= sat_add(in_now, ival);
                            used_reg  <= allow_reg;
                            state_reg <= ST_FINISH;
                        end
                        else if (rate_reg == '0)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else if (in_now >= dl_reg)
                        begin
                            div_dividend_reg <= DW'(in_now - dl_reg);
                            div_divisor_reg  <= DW'(ival);
                            div_start_reg    <= 1'b1;
                            state_reg        <= ST_CU_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_W_CHECK;
                        end
                    end
                end

                ST_CU_DIV:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        q_reg     <= div_quot[TW-1:0];
                        base_reg  <= now_reg - div_rem[TW-1:0];
                        state_reg <= ST_CU_EVAL;
                    end
                end

                ST_CU_EVAL:
                begin
                    if (used_reg > allow_reg && allow_reg == '0)
                    begin
                        // debt with no allowance never shrinks
                        dl_reg    <= sat_add(base_reg, ival);
                        state_reg <= ST_W_CHECK;
                    end
                    else if (used_reg > allow_reg)
                    begin
                        div_dividend_reg <= DW'(used_reg - 1'b1);
                        div_divisor_reg  <= DW'(allow_reg);
                        div_start_reg    <= 1'b1;
                        state_reg        <= ST_S_DIV;
                    end
                    else
                    begin
                        s_reg     <= '0;
                        state_reg <= ST_S_EVAL;
                    end
                end

                ST_S_DIV:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        s_reg     <= div_quot[CW-1:0];
                        state_reg <= ST_S_EVAL;
                    end
                end

                ST_S_EVAL:
                begin
                    if (TW'(s_reg) > q_reg)
                    begin
                        // carry the debt: used -= (q + 1) * allowance
                        m_reg      <= CW'(q_reg + 1'b1);
                        ashift_reg <= allow_reg;
                        dl_reg     <= sat_add(base_reg, ival);
                        state_reg  <= ST_MUL;
                    end
                    else if (TW'(s_reg) == q_reg)
                    begin
                        used_reg  <= '0;
                        dl_reg    <= sat_add(base_reg, ival);
                        state_reg <= ST_W_CHECK;
                    end
                    else
                    begin
                        used_reg  <= '0;
                        dl_reg    <= sat_add(now_reg, ival);
                        state_reg <= ST_W_CHECK;
                    end
                end

                ST_MUL:
                begin
                    if (m_reg == '0)
                    begin
                        state_reg <= ST_W_CHECK;
                    end
                    else
                    begin
                        if (m_reg[0])
                        begin
                            used_reg <= used_reg - ashift_reg;
                        end
                        m_reg      <= m_reg >> 1;
                        ashift_reg <= ashift_reg << 1;
                    end
                end

                ST_W_CHECK:
                begin
                    if (used_reg > allow_reg)
                    begin
                        div_dividend_reg <= DW'({used_reg - allow_reg,
                                                {idrt_pkg::FRACTION_BITS{1'b0}}});
                        div_divisor_reg  <= DW'(rate_reg);
                        div_start_reg    <= 1'b1;
                        state_reg        <= ST_W_DIV;
                    end
                    else
                    begin
                        state_reg <= ST_ADD;
                    end
                end

                ST_W_DIV:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        if (div_quot[DW-1:idrt_pkg::DELAY_W] != '0)
                        begin
                            delay_reg <= '1;
                        end
                        else
                        begin
                            delay_reg <= div_quot[idrt_pkg::DELAY_W-1:0];
                        end
                        state_reg <= ST_ADD;
                    end
                end

                ST_ADD:
                begin
                    used_reg  <= used_sum[CW] ? '1 : used_sum[CW-1:0];
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    // hold until the output slot is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= delay_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = idrt_pkg::M_TDATA_W'(m_data_reg);

endmodule

`default_nettype wire
